FILE: src/ets_pkg.sv
// Shared types and codes for the expression token scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

    localparam int KIND_W = 5;
    localparam int VAL_W  = 31;

    localparam logic [KIND_W-1:0] K_INT   = 5'd0;
    localparam logic [KIND_W-1:0] K_TRUE  = 5'd1;
    localparam logic [KIND_W-1:0] K_FALSE = 5'd2;
    localparam logic [KIND_W-1:0] K_LPAR  = 5'd3;
    localparam logic [KIND_W-1:0] K_RPAR  = 5'd4;
    localparam logic [KIND_W-1:0] K_MUL   = 5'd5;
    localparam logic [KIND_W-1:0] K_DIV   = 5'd6;
    localparam logic [KIND_W-1:0] K_MOD   = 5'd7;
    localparam logic [KIND_W-1:0] K_ADD   = 5'd8;
    localparam logic [KIND_W-1:0] K_SUB   = 5'd9;
    localparam logic [KIND_W-1:0] K_LT    = 5'd10;
    localparam logic [KIND_W-1:0] K_LE    = 5'd11;
    localparam logic [KIND_W-1:0] K_GT    = 5'd12;
    localparam logic [KIND_W-1:0] K_GE    = 5'd13;
    localparam logic [KIND_W-1:0] K_EQ    = 5'd14;
    localparam logic [KIND_W-1:0] K_NOT   = 5'd15;
    localparam logic [KIND_W-1:0] K_NE    = 5'd16;
    localparam logic [KIND_W-1:0] K_AND   = 5'd17;
    localparam logic [KIND_W-1:0] K_OR    = 5'd18;
    localparam logic [KIND_W-1:0] K_END   = 5'd19;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
    } t_tok;

    // One queue entry: the tokens caused by one input item.
    typedef struct packed {
        logic two;
        logic failed;
        t_tok tok0;
        t_tok tok1;
    } t_entry;

endpackage

`default_nettype wire

FILE: src/ets_front.sv
// Front end of the expression token scanner: takes characters, keeps the
// pending lexeme and builds one queue entry per item that yields tokens.
// Depends on ets_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ets_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_end_marker,
    output ets_pkg::t_entry    o_entry,
    output logic               o_wr
);
    import ets_pkg::*;

    localparam logic [3:0] C_NONE = 4'd0;
    localparam logic [3:0] C_NUM  = 4'd1;
    localparam logic [3:0] C_WT   = 4'd2;
    localparam logic [3:0] C_WF   = 4'd3;
    localparam logic [3:0] C_LT   = 4'd4;
    localparam logic [3:0] C_GT   = 4'd5;
    localparam logic [3:0] C_EQ   = 4'd6;
    localparam logic [3:0] C_NOT  = 4'd7;
    localparam logic [3:0] C_AND  = 4'd8;
    localparam logic [3:0] C_OR   = 4'd9;

    localparam logic [34:0] MAX31 = 35'h7FFF_FFFF;

    function automatic logic [7:0] f_word_char(input logic is_t, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = is_t ? "t" : "f";
            3'd1:    ch = is_t ? "r" : "a";
            3'd2:    ch = is_t ? "u" : "l";
            3'd3:    ch = is_t ? "e" : "s";
            3'd4:    ch = is_t ? 8'h00 : "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic [3:0]       r_cls, n_cls;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic [2:0]       r_pos, n_pos;
    logic             r_brk, n_brk;
    logic             r_err, n_err;

    logic        c_digit, c_alpha, c_ws;
    logic [34:0] mul;
    logic [2:0]  wlen;
    logic [7:0]  wexp;
    logic        fl_v, fl_err;
    t_tok        fl_tok;
    logic        fr_v, fr_err;
    t_tok        fr_tok;
    logic [3:0]  fr_cls;
    logic [2:0]  fr_pos;
    logic        use_flush, use_fresh;
    logic        sec_v;
    t_tok        sec_tok;

    assign c_digit = (i_char_code >= "0") && (i_char_code <= "9");
    assign c_alpha = ((i_char_code >= "a") && (i_char_code <= "z")) ||
                     ((i_char_code >= "A") && (i_char_code <= "Z"));
    assign c_ws    = (i_char_code == " ") || (i_char_code == 8'h09) ||
                     (i_char_code == 8'h0D) || (i_char_code == 8'h0A);
    assign mul     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                     {31'b0, i_char_code[3:0]};
    assign wlen    = (r_cls == C_WT) ? 3'd4 : 3'd5;
    assign wexp    = f_word_char(r_cls == C_WT, r_pos);

    // token released by the pending lexeme when it ends
    always_comb begin
        fl_v   = 1'b0;
        fl_err = 1'b0;
        fl_tok = '0;
        case (r_cls)
            C_NUM: begin
                if (r_ovf) begin
                    fl_err = 1'b1;
                end else begin
                    fl_v         = 1'b1;
                    fl_tok.kind  = K_INT;
                    fl_tok.value = r_acc;
                end
            end
            C_WT, C_WF: begin
                if (!r_brk && r_pos == wlen) begin
                    fl_v        = 1'b1;
                    fl_tok.kind = (r_cls == C_WT) ? K_TRUE : K_FALSE;
                end else begin
                    fl_err = 1'b1;
                end
            end
            C_LT: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_LT;
            end
            C_GT: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_GT;
            end
            C_NOT: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_NOT;
            end
            C_EQ, C_AND, C_OR: begin
                fl_err = 1'b1;
            end
            default: begin
                fl_v = 1'b0;
            end
        endcase
    end

    // classification of a character with nothing pending
    always_comb begin
        fr_v   = 1'b0;
        fr_err = 1'b0;
        fr_tok = '0;
        fr_cls = C_NONE;
        fr_pos = 3'd0;
        if (c_ws) begin
            fr_cls = C_NONE;
        end else if (c_digit) begin
            fr_cls = C_NUM;
        end else begin
            case (i_char_code)
                "(": begin fr_v = 1'b1; fr_tok.kind = K_LPAR; end
                ")": begin fr_v = 1'b1; fr_tok.kind = K_RPAR; end
                "*": begin fr_v = 1'b1; fr_tok.kind = K_MUL; end
                "/": begin fr_v = 1'b1; fr_tok.kind = K_DIV; end
                "%": begin fr_v = 1'b1; fr_tok.kind = K_MOD; end
                "+": begin fr_v = 1'b1; fr_tok.kind = K_ADD; end
                "-": begin fr_v = 1'b1; fr_tok.kind = K_SUB; end
                "<": fr_cls = C_LT;
                ">": fr_cls = C_GT;
                "=": fr_cls = C_EQ;
                "!": fr_cls = C_NOT;
                "&": fr_cls = C_AND;
                "|": fr_cls = C_OR;
                "t": begin fr_cls = C_WT; fr_pos = 3'd1; end
                "f": begin fr_cls = C_WF; fr_pos = 3'd1; end
                default: fr_err = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_cls     = r_cls;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        n_brk     = r_brk;
        use_flush = 1'b0;
        use_fresh = 1'b0;
        sec_v     = 1'b0;
        sec_tok   = '0;
        if (i_acc) begin
            if (i_end_marker) begin
                use_flush    = 1'b1;
                n_cls        = C_NONE;
                n_acc        = '0;
                n_ovf        = 1'b0;
                n_pos        = 3'd0;
                n_brk        = 1'b0;
                sec_v        = 1'b1;
                sec_tok.kind = K_END;
            end else begin
                case (r_cls)
                    C_NUM: begin
                        if (c_digit) begin
                            if (mul > MAX31) begin
                                n_ovf = 1'b1;
                                n_acc = MAX31[VAL_W-1:0];
                            end else begin
                                n_acc = mul[VAL_W-1:0];
                            end
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    C_WT, C_WF: begin
                        if (c_alpha) begin
                            if (!r_brk && r_pos < wlen && i_char_code == wexp) begin
                                n_pos = r_pos + 3'd1;
                            end else begin
                                n_brk = 1'b1;
                            end
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    C_LT, C_GT, C_EQ, C_NOT: begin
                        if (i_char_code == "=") begin
                            n_cls = C_NONE;
                            sec_v = 1'b1;
                            case (r_cls)
                                C_LT:    sec_tok.kind = K_LE;
                                C_GT:    sec_tok.kind = K_GE;
                                C_EQ:    sec_tok.kind = K_EQ;
                                default: sec_tok.kind = K_NE;
                            endcase
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    C_AND: begin
                        if (i_char_code == "&") begin
                            n_cls        = C_NONE;
                            sec_v        = 1'b1;
                            sec_tok.kind = K_AND;
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    C_OR: begin
                        if (i_char_code == "|") begin
                            n_cls        = C_NONE;
                            sec_v        = 1'b1;
                            sec_tok.kind = K_OR;
                        end else begin
                            use_fresh = 1'b1;
                        end
                    end
                    default: begin
                        use_fresh = 1'b1;
                    end
                endcase
                if (use_fresh) begin
                    use_flush = 1'b1;
                    n_cls     = fr_cls;
                    n_acc     = {27'b0, i_char_code[3:0]} & {VAL_W{c_digit}};
                    n_ovf     = 1'b0;
                    n_pos     = fr_pos;
                    n_brk     = 1'b0;
                    sec_v     = fr_v;
                    sec_tok   = fr_tok;
                end
            end
        end
        n_err = r_err | (use_flush & fl_err) | (use_fresh & fr_err);
    end

    always_comb begin
        o_entry.failed = n_err;
        if (use_flush && fl_v) begin
            o_entry.two  = sec_v;
            o_entry.tok0 = fl_tok;
            o_entry.tok1 = sec_tok;
        end else begin
            o_entry.two  = 1'b0;
            o_entry.tok0 = sec_tok;
            o_entry.tok1 = sec_tok;
        end
    end

    assign o_wr = i_acc & ((use_flush & fl_v) | sec_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls <= C_NONE;
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_pos <= 3'd0;
            r_brk <= 1'b0;
            r_err <= 1'b0;
        end else begin
            r_cls <= n_cls;
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_pos <= n_pos;
            r_brk <= n_brk;
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

FILE: src/ets_fifo.sv
// Entry queue between the scanner front end and the token back end.
// Depends on ets_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ets_fifo #(
    parameter int P_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire ets_pkg::t_entry i_data,
    input  wire logic          i_rd,
    output ets_pkg::t_entry    o_head,
    output logic               o_full,
    output logic               o_valid
);
    import ets_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_entry          r_mem [P_DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == AW'(P_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == AW'(P_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: src/ets_back.sv
// Back end of the expression token scanner: splits queue entries into
// single tokens and holds the result in an output register.
// Depends on ets_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ets_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ets_pkg::t_entry             i_head,
    input  wire logic                        i_valid,
    output logic                             o_rd,
    input  wire logic                        i_pop,
    output logic                             o_empty,
    output logic [ets_pkg::KIND_W-1:0]       o_token_kind,
    output logic [ets_pkg::VAL_W-1:0]        o_int_value,
    output logic                             o_failed,
    output logic                             o_last_of_run
);
    import ets_pkg::*;

    logic  r_vld, n_vld;
    logic  r_idx, n_idx;
    t_tok  r_tok;
    logic  r_fail;
    logic  r_last;
    logic  ld;
    logic  last;
    t_tok  sel;

    assign ld   = i_valid && (!r_vld || i_pop);
    assign last = !i_head.two || r_idx;
    assign sel  = r_idx ? i_head.tok1 : i_head.tok0;
    assign o_rd = ld && last;

    always_comb begin
        n_vld = r_vld;
        n_idx = r_idx;
        if (ld) begin
            n_vld = 1'b1;
            n_idx = !last;
        end else if (i_pop) begin
            n_vld = 1'b0;
        end
    end

    // hold the shown token until it is popped
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_tok  <= sel;
            r_fail <= i_head.failed;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_idx <= n_idx;
        end
    end

    assign o_empty       = !r_vld;
    assign o_token_kind  = r_tok.kind;
    assign o_int_value   = r_tok.value;
    assign o_failed      = r_fail;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

FILE: src/expression_token_scanner.sv
// Top level of the expression token scanner.
// Depends on ets_pkg, ets_front, ets_fifo and ets_back.
//
// Takes one character (or an end marker) per clock while full is low and
// shows one token per clock on the result side while pop is high. The
// front end decides each character combinationally against the one pending
// lexeme it holds, so an item can follow in every cycle; the first token of
// an item passes through the entry queue and the output register before it
// is visible. An item yields zero, one or two tokens; two-token items (a
// lexeme closed by a following operator, or by the end marker) are shown
// one token at a time, so a steady stream of them fills the P_DEPTH-entry
// queue and then raises full. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module expression_token_scanner #(
    parameter int P_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  i_char_code,
    input  wire logic                        i_end_marker,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [ets_pkg::KIND_W-1:0]       o_token_kind,
    output logic [ets_pkg::VAL_W-1:0]        o_int_value,
    output logic                             o_failed,
    output logic                             o_last_of_run
);
    import ets_pkg::*;

    logic   acc;
    logic   q_wr;
    logic   q_rd;
    logic   q_valid;
    t_entry q_in;
    t_entry q_head;

    assign acc = push && !full;

    ets_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .o_entry      (q_in),
        .o_wr         (q_wr)
    );

    ets_fifo #(
        .P_DEPTH (P_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .i_rd    (q_rd),
        .o_head  (q_head),
        .o_full  (full),
        .o_valid (q_valid)
    );

    ets_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_valid       (q_valid),
        .o_rd          (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_token_kind  (o_token_kind),
        .o_int_value   (o_int_value),
        .o_failed      (o_failed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

FILE: src/ets_chk.sv
// Port-level checks for the expression token scanner, bound to the top.
// Depends on ets_pkg and expression_token_scanner.
`timescale 1ns / 1ps
`default_nettype none

module ets_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    input  wire logic                        full,
    input  wire logic [7:0]                  i_char_code,
    input  wire logic                        i_end_marker,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire logic [ets_pkg::KIND_W-1:0]  o_token_kind,
    input  wire logic [ets_pkg::VAL_W-1:0]   o_int_value,
    input  wire logic                        o_failed,
    input  wire logic                        o_last_of_run
);
    import ets_pkg::*;

    logic r_seen;

    // remember a failed flag once an item carrying it has left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (pop && !empty && o_failed) begin
            r_seen <= 1'b1;
        end
    end

    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && r_seen) |-> o_failed)
        else $error("failed flag dropped after being reported");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != K_INT) |-> (o_int_value == '0))
        else $error("nonzero value on a non-integer token");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == K_END) |-> o_last_of_run)
        else $error("end token not marked last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_kind) &&
                              $stable(o_int_value) && $stable(o_last_of_run)))
        else $error("stalled item changed");

endmodule

bind expression_token_scanner ets_chk u_chk (.*);

`default_nettype wire
